>>> rtl/sd_spi_init_and_block_read_unit_assert.svh
// ----------------------------------------------------------------------------
// SD SPI sequencer assertion macros
// Shared property templates for the sequencer's port checker.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_AND_BLOCK_READ_UNIT_ASSERT_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is low
`define SDSPI_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low
`define SDSPI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Codes, widths and command frame tables shared by the sequencer files.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    // Payload bytes in one block
    localparam int BLOCK_SIZE = 512;

    // Byte counter covers the block length and the 8-bit limits
    localparam int CNT_W = ($clog2(BLOCK_SIZE + 1) > 8) ? $clog2(BLOCK_SIZE + 1) : 8;

    localparam logic [7:0]  BYTE_IDLE   = 8'hff;
    localparam logic [7:0]  TOKEN_START = 8'hfe;
    localparam logic [7:0]  ECHO_CHECK  = 8'haa;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  CMD_START   = 8'h40;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_OTHER   = 8'h01;
    localparam logic [31:0] ARG_CMD8    = 32'h0000_01aa;
    localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;

    // Frame: command, four argument bytes, crc, two fillers
    localparam int FRAME_LEN  = 8;
    localparam int R7_LEN     = 4;
    localparam int CRC_LEN    = 2;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_READ = 2'd1,
        OP_SLOT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RESPONSE_LIMIT = 3'd0,
        REG_TOKEN_LIMIT    = 3'd1,
        REG_INIT_LIMIT     = 3'd2,
        REG_DUMMY_BYTES    = 3'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        CMD_GO_IDLE  = 3'd0,
        CMD_IF_COND  = 3'd1,
        CMD_APP      = 3'd2,
        CMD_OP_COND  = 3'd3,
        CMD_READ_BLK = 3'd4
    } cmd_t;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_DUMMY = 9'b000000010,
        PH_FRAME = 9'b000000100,
        PH_WAIT  = 9'b000001000,
        PH_REL   = 9'b000010000,
        PH_R7    = 9'b000100000,
        PH_TOKEN = 9'b001000000,
        PH_DATA  = 9'b010000000,
        PH_CRC   = 9'b100000000
    } phase_t;

    // Byte of a command frame at position idx
    function automatic logic [7:0] frame_byte(cmd_t cmd, logic [2:0] idx,
                                              logic [31:0] blk);
        logic [31:0] arg;
        logic [7:0]  code;
        logic [7:0]  crc;
        logic [7:0]  b;
        unique case (cmd)
            CMD_GO_IDLE:  begin arg = '0;         code = 8'd0;  crc = CRC_CMD0;  end
            CMD_IF_COND:  begin arg = ARG_CMD8;   code = 8'd8;  crc = CRC_CMD8;  end
            CMD_APP:      begin arg = '0;         code = 8'd55; crc = CRC_OTHER; end
            CMD_OP_COND:  begin arg = ARG_ACMD41; code = 8'd41; crc = CRC_OTHER; end
            CMD_READ_BLK: begin arg = blk;        code = 8'd17; crc = CRC_OTHER; end
            default:      begin arg = '0;         code = 8'd0;  crc = CRC_OTHER; end
        endcase
        unique case (idx)
            3'd0:    b = CMD_START | code;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            3'd5:    b = crc;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/sdspi_if.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdspi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;

    modport source (output valid, output op, output block_address, output rx_byte,
                    input ready);
    modport sink (input valid, input op, input block_address, input rx_byte,
                  output ready);
endinterface

interface sdspi_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       card_select;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last_data;
    logic [1:0] status;

    modport source (output valid, output tx_byte, output card_select, output fast_clock,
                    output data_valid, output data_byte, output last_data,
                    output status, input ready);
    modport sink (input valid, input tx_byte, input card_select, input fast_clock,
                  input data_valid, input data_byte, input last_data,
                  input status, output ready);
endinterface

interface sdspi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/sd_spi_init_and_block_read_unit.sv
// ----------------------------------------------------------------------------
// SD card SPI-mode init and block read sequencer
// Byte-slot sequencer: each request reports one slot or starts an operation,
// each response names the next slot's byte and chip select level.
// ----------------------------------------------------------------------------
// One request is taken per clock while no response waits or it is being taken.
// Each request that carries an op other than the unused code produces exactly
// one response, registered in the cycle after acceptance; the unused op code
// is taken and produces none. The next state and response are worked out
// combinationally from the sequencer registers, and a single response
// register decouples the two sides, so a request is still taken while a
// finished response waits, as long as the response is being taken in that
// same cycle. Register writes are taken every cycle and should only be
// issued while no operation is in flight. No clearing pass follows reset.
module sd_spi_init_and_block_read_unit (
    input  logic             clk,
    input  logic             rst_n,
    sdspi_req_if.sink        req,
    sdspi_rsp_if.source      rsp,
    sdspi_cfg_if.sink        cfg
);

    typedef logic [sdspi_pkg::CNT_W-1:0] cnt_t;
    typedef logic [sdspi_pkg::CNT_W:0]   cnt_ext_t;

    // Configuration registers
    logic [7:0]  response_limit_reg;
    logic [15:0] token_limit_reg;
    logic [15:0] init_limit_reg;
    logic [7:0]  dummy_bytes_reg;

    // Sequencer state
    sdspi_pkg::phase_t phase_reg, phase_next;
    sdspi_pkg::cmd_t   cmd_reg, cmd_next;
    cnt_t              byte_count_reg, byte_count_next;
    logic [15:0]       attempt_count_reg, attempt_count_next;
    logic [7:0]        saved_response_reg, saved_response_next;
    logic [31:0]       read_block_reg, read_block_next;
    logic              card_ready_reg, card_ready_next;

    // Response register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              card_select_reg, card_select_next;
    logic              data_valid_reg, data_valid_next;
    logic [7:0]        data_byte_reg, data_byte_next;
    logic              last_data_reg, last_data_next;
    sdspi_pkg::status_t status_reg, status_next;

    logic        req_fire;
    logic        rsp_load;
    cnt_ext_t    count_inc;
    logic [15:0] attempt_inc;
    logic [7:0]  response_min;
    logic [15:0] token_min;
    logic [15:0] init_min;
    logic [7:0]  dummy_min;

    // Handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign rsp_load  = req_fire && (sdspi_pkg::op_t'(req.op) != sdspi_pkg::OP_NONE);
    assign cfg.ready = 1'b1;

    // Zero limits count as one
    assign response_min = (response_limit_reg == 8'd0) ? 8'd1 : response_limit_reg;
    assign token_min    = (token_limit_reg == 16'd0) ? 16'd1 : token_limit_reg;
    assign init_min     = (init_limit_reg == 16'd0) ? 16'd1 : init_limit_reg;
    assign dummy_min    = (dummy_bytes_reg == 8'd0) ? 8'd1 : dummy_bytes_reg;

    assign count_inc   = cnt_ext_t'(byte_count_reg) + cnt_ext_t'(1);
    assign attempt_inc = attempt_count_reg + 16'd1;

    // Advance the sequencer by one request
    always_comb
    begin
        phase_next          = phase_reg;
        cmd_next            = cmd_reg;
        byte_count_next     = byte_count_reg;
        attempt_count_next  = attempt_count_reg;
        saved_response_next = saved_response_reg;
        read_block_next     = read_block_reg;
        card_ready_next     = card_ready_reg;
        data_valid_next     = 1'b0;
        data_byte_next      = 8'd0;
        last_data_next      = 1'b0;
        status_next         = sdspi_pkg::ST_BUSY;
        tx_byte_next        = sdspi_pkg::BYTE_IDLE;
        card_select_next    = 1'b0;

        unique case (sdspi_pkg::op_t'(req.op))
            sdspi_pkg::OP_INIT:
            begin
                card_ready_next     = 1'b0;
                phase_next          = sdspi_pkg::PH_DUMMY;
                byte_count_next     = '0;
                attempt_count_next  = 16'd0;
                saved_response_next = 8'd0;
            end
            sdspi_pkg::OP_READ:
            begin
                read_block_next = req.block_address;
                phase_next      = sdspi_pkg::PH_FRAME;
                cmd_next        = sdspi_pkg::CMD_READ_BLK;
                byte_count_next = '0;
            end
            sdspi_pkg::OP_SLOT:
            begin
                unique case (phase_reg)
                    sdspi_pkg::PH_IDLE:
                    begin
                        phase_next = sdspi_pkg::PH_IDLE;
                    end
                    sdspi_pkg::PH_DUMMY:
                    begin
                        byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                        if (count_inc >= cnt_ext_t'(dummy_min))
                        begin
                            phase_next      = sdspi_pkg::PH_FRAME;
                            cmd_next        = sdspi_pkg::CMD_GO_IDLE;
                            byte_count_next = '0;
                        end
                    end
                    sdspi_pkg::PH_FRAME:
                    begin
                        byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                        if (count_inc >= cnt_ext_t'(sdspi_pkg::FRAME_LEN))
                        begin
                            phase_next      = sdspi_pkg::PH_WAIT;
                            byte_count_next = '0;
                        end
                    end
                    sdspi_pkg::PH_WAIT:
                    begin
                        if (req.rx_byte != sdspi_pkg::BYTE_IDLE)
                        begin
                            saved_response_next = req.rx_byte;
                            byte_count_next     = '0;
                            if (cmd_reg == sdspi_pkg::CMD_IF_COND)
                            begin
                                phase_next = sdspi_pkg::PH_R7;
                            end
                            else if (cmd_reg == sdspi_pkg::CMD_READ_BLK)
                            begin
                                if (req.rx_byte == sdspi_pkg::R1_READY)
                                begin
                                    phase_next         = sdspi_pkg::PH_TOKEN;
                                    attempt_count_next = 16'd0;
                                end
                                else
                                begin
                                    phase_next  = sdspi_pkg::PH_IDLE;
                                    status_next = sdspi_pkg::ST_FAIL;
                                end
                            end
                            else
                            begin
                                phase_next = sdspi_pkg::PH_REL;
                            end
                        end
                        else
                        begin
                            byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                            if (count_inc >= cnt_ext_t'(response_min))
                            begin
                                phase_next  = sdspi_pkg::PH_IDLE;
                                status_next = sdspi_pkg::ST_FAIL;
                            end
                        end
                    end
                    sdspi_pkg::PH_R7:
                    begin
                        byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                        if (count_inc >= cnt_ext_t'(sdspi_pkg::R7_LEN))
                        begin
                            // Drop the saved R1 on a bad echo so the check fails
                            if (req.rx_byte != sdspi_pkg::ECHO_CHECK)
                            begin
                                saved_response_next = 8'd0;
                            end
                            phase_next      = sdspi_pkg::PH_REL;
                            byte_count_next = '0;
                        end
                    end
                    sdspi_pkg::PH_REL:
                    begin
                        phase_next = sdspi_pkg::PH_IDLE;
                        unique case (cmd_reg)
                            sdspi_pkg::CMD_GO_IDLE:
                            begin
                                if (saved_response_reg == sdspi_pkg::R1_IDLE)
                                begin
                                    phase_next      = sdspi_pkg::PH_FRAME;
                                    cmd_next        = sdspi_pkg::CMD_IF_COND;
                                    byte_count_next = '0;
                                end
                                else
                                begin
                                    status_next = sdspi_pkg::ST_FAIL;
                                end
                            end
                            sdspi_pkg::CMD_IF_COND:
                            begin
                                if (saved_response_reg == sdspi_pkg::R1_IDLE)
                                begin
                                    attempt_count_next = 16'd0;
                                    phase_next         = sdspi_pkg::PH_FRAME;
                                    cmd_next           = sdspi_pkg::CMD_APP;
                                    byte_count_next    = '0;
                                end
                                else
                                begin
                                    status_next = sdspi_pkg::ST_FAIL;
                                end
                            end
                            sdspi_pkg::CMD_APP:
                            begin
                                phase_next      = sdspi_pkg::PH_FRAME;
                                cmd_next        = sdspi_pkg::CMD_OP_COND;
                                byte_count_next = '0;
                            end
                            sdspi_pkg::CMD_OP_COND:
                            begin
                                if (saved_response_reg == sdspi_pkg::R1_READY)
                                begin
                                    card_ready_next = 1'b1;
                                    status_next     = sdspi_pkg::ST_OK;
                                end
                                else if (saved_response_reg == sdspi_pkg::R1_IDLE)
                                begin
                                    attempt_count_next = attempt_inc;
                                    if (attempt_inc >= init_min)
                                    begin
                                        status_next = sdspi_pkg::ST_FAIL;
                                    end
                                    else
                                    begin
                                        phase_next      = sdspi_pkg::PH_FRAME;
                                        cmd_next        = sdspi_pkg::CMD_APP;
                                        byte_count_next = '0;
                                    end
                                end
                                else
                                begin
                                    status_next = sdspi_pkg::ST_FAIL;
                                end
                            end
                            default:
                            begin
                                status_next = sdspi_pkg::ST_OK;
                            end
                        endcase
                    end
                    sdspi_pkg::PH_TOKEN:
                    begin
                        if (req.rx_byte == sdspi_pkg::TOKEN_START)
                        begin
                            phase_next      = sdspi_pkg::PH_DATA;
                            byte_count_next = '0;
                        end
                        else if (req.rx_byte != sdspi_pkg::BYTE_IDLE)
                        begin
                            phase_next  = sdspi_pkg::PH_IDLE;
                            status_next = sdspi_pkg::ST_FAIL;
                        end
                        else
                        begin
                            attempt_count_next = attempt_inc;
                            if (attempt_inc >= token_min)
                            begin
                                phase_next  = sdspi_pkg::PH_IDLE;
                                status_next = sdspi_pkg::ST_FAIL;
                            end
                        end
                    end
                    sdspi_pkg::PH_DATA:
                    begin
                        data_valid_next = 1'b1;
                        data_byte_next  = req.rx_byte;
                        byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                        if (count_inc >= cnt_ext_t'(sdspi_pkg::BLOCK_SIZE))
                        begin
                            last_data_next  = 1'b1;
                            phase_next      = sdspi_pkg::PH_CRC;
                            byte_count_next = '0;
                        end
                    end
                    sdspi_pkg::PH_CRC:
                    begin
                        byte_count_next = count_inc[sdspi_pkg::CNT_W-1:0];
                        if (count_inc >= cnt_ext_t'(sdspi_pkg::CRC_LEN))
                        begin
                            phase_next      = sdspi_pkg::PH_REL;
                            byte_count_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = sdspi_pkg::PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Next slot byte and chip select follow the new phase
        if (phase_next == sdspi_pkg::PH_FRAME)
        begin
            tx_byte_next     = sdspi_pkg::frame_byte(cmd_next, byte_count_next[2:0],
                                                     read_block_next);
            card_select_next = 1'b1;
        end
        else if (phase_next != sdspi_pkg::PH_IDLE && phase_next != sdspi_pkg::PH_DUMMY)
        begin
            card_select_next = 1'b1;
        end
    end

    // Response valid: load on a producing request, drop when taken
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= sdspi_pkg::PH_IDLE;
            cmd_reg            <= sdspi_pkg::CMD_GO_IDLE;
            byte_count_reg     <= '0;
            attempt_count_reg  <= 16'd0;
            saved_response_reg <= 8'd0;
            read_block_reg     <= 32'd0;
            card_ready_reg     <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (rsp_load)
            begin
                phase_reg          <= phase_next;
                cmd_reg            <= cmd_next;
                byte_count_reg     <= byte_count_next;
                attempt_count_reg  <= attempt_count_next;
                saved_response_reg <= saved_response_next;
                read_block_reg     <= read_block_next;
                card_ready_reg     <= card_ready_next;
            end
        end
    end

    // Capture the response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            tx_byte_reg     <= tx_byte_next;
            card_select_reg <= card_select_next;
            data_valid_reg  <= data_valid_next;
            data_byte_reg   <= data_byte_next;
            last_data_reg   <= last_data_next;
            status_reg      <= status_next;
        end
    end

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response_limit_reg <= 8'd32;
            token_limit_reg    <= 16'd1024;
            init_limit_reg     <= 16'd1024;
            dummy_bytes_reg    <= 8'd10;
        end
        else if (cfg.valid)
        begin
            unique case (sdspi_pkg::reg_index_t'(cfg.reg_index))
                sdspi_pkg::REG_RESPONSE_LIMIT: response_limit_reg <= cfg.wdata[7:0];
                sdspi_pkg::REG_TOKEN_LIMIT:    token_limit_reg    <= cfg.wdata;
                sdspi_pkg::REG_INIT_LIMIT:     init_limit_reg     <= cfg.wdata;
                sdspi_pkg::REG_DUMMY_BYTES:    dummy_bytes_reg    <= cfg.wdata[7:0];
                default:                       dummy_bytes_reg    <= dummy_bytes_reg;
            endcase
        end
    end

    // Drive the response channel
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.tx_byte     = tx_byte_reg;
    assign rsp.card_select = card_select_reg;
    assign rsp.fast_clock  = card_ready_reg;
    assign rsp.data_valid  = data_valid_reg;
    assign rsp.data_byte   = data_byte_reg;
    assign rsp.last_data   = last_data_reg;
    assign rsp.status      = status_reg;

endmodule

>>> rtl/sdspi_checker.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer port checker
// Watches the sequencer's ports for response ordering and field consistency.
// ----------------------------------------------------------------------------
`include "sd_spi_init_and_block_read_unit_assert.svh"

module sdspi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] tx_byte,
    input logic       card_select,
    input logic       data_valid,
    input logic       last_data,
    input logic [1:0] status
);

    logic shown;
    logic done;

    assign shown = rsp_valid;
    assign done  = rsp_valid && (status != sdspi_pkg::ST_BUSY);

    // A stalled response stays offered
    `SDSPI_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // The last payload byte is always a payload byte
    `SDSPI_ASSERT_SAME(a_last_is_data, clk, rst_n, shown && last_data, data_valid, "last_data without data_valid")

    // Payload bytes arrive with the card selected and the read still running
    `SDSPI_ASSERT_SAME(a_data_busy, clk, rst_n, shown && data_valid, card_select && (status == sdspi_pkg::ST_BUSY), "payload byte outside a running read")

    // A finished operation leaves the card deselected and the bus idle
    `SDSPI_ASSERT_SAME(a_done_idle, clk, rst_n, done, !card_select && (tx_byte == sdspi_pkg::BYTE_IDLE), "operation ended with the card still driven")

endmodule

bind sd_spi_init_and_block_read_unit sdspi_checker u_sdspi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .tx_byte     (rsp.tx_byte),
    .card_select (rsp.card_select),
    .data_valid  (rsp.data_valid),
    .last_data   (rsp.last_data),
    .status      (rsp.status)
);
